// ===== design/bsoc_pkg.sv =====
// Package for the battery charge LED bar controller.
// Holds mode codes, register indexes, reset values, shared structs and the bar function.
// No dependencies.
`timescale 1ns / 1ps

package bsoc_pkg;

   localparam logic [1:0] MODE_STARTUP   = 2'd0;
   localparam logic [1:0] MODE_NORMAL    = 2'd1;
   localparam logic [1:0] MODE_CHARGE    = 2'd2;
   localparam logic [1:0] MODE_DISCHARGE = 2'd3;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FAULT_MASK       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_TICKS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_HALF_TICKS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP_HOLD_TICKS = 2'd3;

   localparam logic [15:0] FAULT_MASK_RESET       = 16'h2FFA;
   localparam logic [7:0]  SHOW_TICKS_RESET       = 8'd50;
   localparam logic [6:0]  BLINK_HALF_TICKS_RESET = 7'd5;
   localparam logic [7:0]  SLEEP_HOLD_TICKS_RESET = 8'd30;

   localparam logic [6:0] SOC_FULL    = 7'd100;
   localparam logic [6:0] SOC_LEVEL_1 = 7'd20;
   localparam logic [6:0] SOC_LEVEL_2 = 7'd40;
   localparam logic [6:0] SOC_LEVEL_3 = 7'd60;
   localparam logic [6:0] SOC_LEVEL_4 = 7'd80;

   localparam logic [7:0] HOLD_COUNT_MAX = 8'hFF;
   localparam logic [4:0] BAR_ALL_ON     = 5'h1F;

   typedef struct packed {
      logic [15:0] fault_mask;
      logic [7:0]  show_ticks;
      logic [6:0]  blink_half_ticks;
      logic [7:0]  sleep_hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic        tick_due;
      logic        startup_busy;
      logic        key_pressed;
      logic        charging;
      logic        discharging;
      logic [6:0]  state_of_charge;
      logic [15:0] fault_word;
      logic        temp_break_fault;
      logic        discharge_overcurrent_fault;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       showing;
      logic [7:0] show_count;
      logic [7:0] blink_count;
      logic [4:0] blink_pattern;
      logic [7:0] hold_count;
      logic       run_led;
      logic [4:0] bar_leds;
      logic       alarm_led;
      logic       sleep_flag;
   } state_type;

   typedef struct packed {
      logic       run_led;
      logic [4:0] bar_leds;
      logic       alarm_led;
      logic       sleep_request;
   } rsp_type;

   function automatic logic [4:0] steady_bar(input logic [6:0] soc);
      logic [4:0] bar;
      bar    = '0;
      bar[0] = (soc != 7'd0);
      bar[1] = (soc >= SOC_LEVEL_1);
      bar[2] = (soc >= SOC_LEVEL_2);
      bar[3] = (soc >= SOC_LEVEL_3);
      bar[4] = (soc >= SOC_LEVEL_4);
      return bar;
   endfunction

endpackage

// ===== design/bsoc_step.sv =====
// Next-state logic for one scheduler call of the LED bar controller.
// Depends on bsoc_pkg (mode codes, structs, bar function).
`timescale 1ns / 1ps

module bsoc_step (
   input  bsoc_pkg::cfg_type   cfg,
   input  bsoc_pkg::req_type   req,
   input  bsoc_pkg::state_type state_cur,
   output bsoc_pkg::state_type state_nxt
);

   logic [6:0] soc;
   logic [8:0] show_next;
   logic [7:0] blink_next;
   logic [7:0] blink_limit;
   logic [4:0] seg_off;
   logic [7:0] hold_next;
   logic       fault;

   always_comb begin
      soc = (req.state_of_charge > bsoc_pkg::SOC_FULL) ? bsoc_pkg::SOC_FULL
                                                       : req.state_of_charge;
      show_next   = {1'b0, state_cur.show_count} + 9'd1;
      blink_next  = state_cur.blink_count + 8'd1;
      blink_limit = {cfg.blink_half_ticks, 1'b0};
      if (blink_next > blink_limit) begin
         blink_next = 8'd1;
      end
      if (soc < bsoc_pkg::SOC_LEVEL_1) begin
         seg_off = 5'b11110;
      end else if (soc < bsoc_pkg::SOC_LEVEL_2) begin
         seg_off = 5'b11101;
      end else if (soc < bsoc_pkg::SOC_LEVEL_3) begin
         seg_off = 5'b11011;
      end else if (soc < bsoc_pkg::SOC_LEVEL_4) begin
         seg_off = 5'b10111;
      end else if (soc < bsoc_pkg::SOC_FULL) begin
         seg_off = 5'b01111;
      end else begin
         seg_off = bsoc_pkg::BAR_ALL_ON;
      end
      fault = ((req.fault_word & cfg.fault_mask) != 16'd0) || req.temp_break_fault ||
              req.discharge_overcurrent_fault;
      hold_next = (state_cur.hold_count < bsoc_pkg::HOLD_COUNT_MAX)
                  ? state_cur.hold_count + 8'd1 : state_cur.hold_count;

      state_nxt = state_cur;
      if (req.tick_due && !req.startup_busy) begin
         case (state_cur.mode)
            bsoc_pkg::MODE_STARTUP: begin
               state_nxt.mode = bsoc_pkg::MODE_NORMAL;
            end
            bsoc_pkg::MODE_NORMAL: begin
               if (!state_cur.showing) begin
                  if (req.key_pressed) begin
                     state_nxt.showing = 1'b1;
                  end
                  if (req.discharging) begin
                     state_nxt.mode = bsoc_pkg::MODE_DISCHARGE;
                  end else if (req.charging) begin
                     state_nxt.mode = bsoc_pkg::MODE_CHARGE;
                  end
               end else begin
                  if (show_next <= {1'b0, cfg.show_ticks}) begin
                     state_nxt.show_count = show_next[7:0];
                     state_nxt.run_led    = 1'b1;
                     state_nxt.bar_leds   = bsoc_pkg::steady_bar(soc);
                  end else begin
                     state_nxt.show_count = 8'd0;
                     state_nxt.showing    = 1'b0;
                     state_nxt.run_led    = 1'b0;
                     state_nxt.bar_leds   = 5'd0;
                  end
                  if (req.key_pressed) begin
                     state_nxt.show_count = 8'd0;
                  end
               end
            end
            bsoc_pkg::MODE_CHARGE: begin
               state_nxt.blink_count = blink_next;
               if (blink_next <= {1'b0, cfg.blink_half_ticks}) begin
                  state_nxt.blink_pattern = seg_off;
               end else begin
                  state_nxt.blink_pattern = bsoc_pkg::BAR_ALL_ON;
               end
               if (req.charging) begin
                  state_nxt.run_led  = 1'b1;
                  state_nxt.bar_leds = (bsoc_pkg::steady_bar(soc) | 5'd1) &
                                       state_nxt.blink_pattern;
               end else begin
                  state_nxt.run_led  = 1'b0;
                  state_nxt.bar_leds = 5'd0;
                  state_nxt.mode     = bsoc_pkg::MODE_NORMAL;
               end
            end
            default: begin
               if (req.discharging) begin
                  state_nxt.run_led  = 1'b1;
                  state_nxt.bar_leds = bsoc_pkg::steady_bar(soc);
               end else begin
                  state_nxt.run_led  = 1'b0;
                  state_nxt.bar_leds = 5'd0;
                  state_nxt.mode     = bsoc_pkg::MODE_NORMAL;
               end
            end
         endcase

         state_nxt.alarm_led = fault ? !state_cur.alarm_led : 1'b0;

         if (req.key_pressed) begin
            state_nxt.hold_count = hold_next;
            if (hold_next >= cfg.sleep_hold_ticks) begin
               state_nxt.sleep_flag = 1'b1;
            end
         end else begin
            state_nxt.hold_count = 8'd0;
         end
      end
   end

endmodule

// ===== design/battery_soc_led_bar_controller.sv =====
// Results are registered: valid the cycle after the request transfer if the output
// register is free, else held in skid. One request per cycle while the skid is empty;
// bsoc_step updates state. Two-entry result buffer: output register plus skid.
// Reset: synchronous, active high; mode startup, bar shown, LEDs off, registers at defaults.
// Top level of the battery charge LED bar controller.
// Depends on bsoc_pkg and bsoc_step.
`timescale 1ns / 1ps

module battery_soc_led_bar_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_tick_due,
   input  logic                                req_startup_busy,
   input  logic                                req_key_pressed,
   input  logic                                req_charging,
   input  logic                                req_discharging,
   input  logic [6:0]                          req_state_of_charge,
   input  logic [15:0]                         req_fault_word,
   input  logic                                req_temp_break_fault,
   input  logic                                req_discharge_overcurrent_fault,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_run_led,
   output logic [4:0]                          rsp_bar_leds,
   output logic                                rsp_alarm_led,
   output logic                                rsp_sleep_request,
   input  logic                                csr_we,
   input  logic [bsoc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bsoc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   bsoc_pkg::cfg_type   cfg_ff;
   bsoc_pkg::state_type state_ff;
   bsoc_pkg::state_type state_in;
   bsoc_pkg::req_type   req;
   bsoc_pkg::rsp_type   rsp_new;
   bsoc_pkg::rsp_type   out_ff;
   bsoc_pkg::rsp_type   out_in;
   bsoc_pkg::rsp_type   skid_ff;
   bsoc_pkg::rsp_type   skid_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   logic                req_xfer;
   logic                rsp_xfer;

   assign req = '{tick_due:                    req_tick_due,
                  startup_busy:                req_startup_busy,
                  key_pressed:                 req_key_pressed,
                  charging:                    req_charging,
                  discharging:                 req_discharging,
                  state_of_charge:             req_state_of_charge,
                  fault_word:                  req_fault_word,
                  temp_break_fault:            req_temp_break_fault,
                  discharge_overcurrent_fault: req_discharge_overcurrent_fault};

   bsoc_step u_step (
      .cfg       (cfg_ff),
      .req       (req),
      .state_cur (state_ff),
      .state_nxt (state_in)
   );

   assign req_ready = !skid_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = out_valid_ff && rsp_ready;

   assign rsp_new = '{run_led:       state_in.run_led,
                      bar_leds:      state_in.bar_leds,
                      alarm_led:     state_in.alarm_led,
                      sleep_request: state_in.sleep_flag};

   // drain the output register first, then place the new transfer
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_xfer) begin
         out_in        = skid_ff;
         out_valid_in  = skid_valid_ff;
         skid_valid_in = 1'b0;
      end
      if (req_xfer) begin
         if (!out_valid_in) begin
            out_in       = rsp_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         state_ff      <= '{mode:          bsoc_pkg::MODE_STARTUP,
                            showing:       1'b1,
                            show_count:    8'd0,
                            blink_count:   8'd0,
                            blink_pattern: 5'd0,
                            hold_count:    8'd0,
                            run_led:       1'b0,
                            bar_leds:      5'd0,
                            alarm_led:     1'b0,
                            sleep_flag:    1'b0};
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (req_xfer) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{fault_mask:       bsoc_pkg::FAULT_MASK_RESET,
                     show_ticks:       bsoc_pkg::SHOW_TICKS_RESET,
                     blink_half_ticks: bsoc_pkg::BLINK_HALF_TICKS_RESET,
                     sleep_hold_ticks: bsoc_pkg::SLEEP_HOLD_TICKS_RESET};
      end else if (csr_we) begin
         case (csr_index)
            bsoc_pkg::CSR_FAULT_MASK:       cfg_ff.fault_mask       <= csr_wdata;
            bsoc_pkg::CSR_SHOW_TICKS:       cfg_ff.show_ticks       <= csr_wdata[7:0];
            bsoc_pkg::CSR_BLINK_HALF_TICKS: cfg_ff.blink_half_ticks <= csr_wdata[6:0];
            bsoc_pkg::CSR_SLEEP_HOLD_TICKS: cfg_ff.sleep_hold_ticks <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_run_led       = out_ff.run_led;
   assign rsp_bar_leds      = out_ff.bar_leds;
   assign rsp_alarm_led     = out_ff.alarm_led;
   assign rsp_sleep_request = out_ff.sleep_request;

endmodule
